@@ rtl/core/sitda_pkg.sv @@
package sitda_pkg;

	localparam int VALUE_W         = 32;
	localparam int NUM_DIGITS      = 10;
	localparam int DIGIT_W         = 4;
	localparam int BCD_W           = NUM_DIGITS * DIGIT_W;
	localparam int IDX_W           = 4;
	// shift-and-add-3 iterations done in each conversion stage (4 stages x 8 = 32 bits)
	localparam int STEPS_PER_STAGE = 8;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;

	typedef struct packed {
		logic               neg;
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} conv_t;

	// eight double-dabble iterations: correct every digit >= 5, then shift in one binary bit
	function automatic conv_t dabble_steps(conv_t d);
		conv_t              r;
		logic [DIGIT_W-1:0] dg;
		r = d;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				dg = r.bcd[k*DIGIT_W +: DIGIT_W];
				if (dg >= 4'd5) begin
					r.bcd[k*DIGIT_W +: DIGIT_W] = dg + 4'd3;
				end
			end
			{r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
		end
		return r;
	endfunction

	// index of the most significant nonzero digit, zero when all digits are zero
	function automatic logic [IDX_W-1:0] top_digit(logic [BCD_W-1:0] bcd);
		logic [IDX_W-1:0] t;
		t = '0;
		for (int k = 1; k < NUM_DIGITS; k++) begin
			if (bcd[k*DIGIT_W +: DIGIT_W] != '0) begin
				t = IDX_W'(k);
			end
		end
		return t;
	endfunction

endpackage

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII text.
//
// Input channel: value (signed 32 bits) with value_valid / value_stall. An item
// is taken at a rising edge with value_valid high and value_stall low.
// Output channel: char_code (8 bits) and last with char_valid / char_stall. Each
// item gives 1 to 11 characters, most significant first: '-' for negatives,
// then the digits without leading zeros; zero gives a single '0'. last marks the
// final character of each number.
// Path: the accepting edge loads the magnitude stage, then the item moves through
// four double-dabble stages into the serializer, each of which registers it;
// a stall can hold it in any of them.
// Throughput: the serializer sends one character per cycle while char_stall is
// low. The pipeline accepts one item per cycle while it has room and keeps up
// to five items queued in its stages.
// Reset (arst_n low, asynchronous) empties the pipeline and the serializer.
// When the receiver stalls, the shown character holds; stages behind it fill up
// and value_stall rises once all of them hold an item.
module signed_int_to_decimal_ascii
	import sitda_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      value_valid,
	output logic                      value_stall,
	output logic [7:0]                char_code,
	output logic                      last,
	output logic                      char_valid,
	input  logic                      char_stall
);

	conv_t data_s1, data_s2, data_s3, data_s4, data_s5;
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic  rdy1, rdy2, rdy3, rdy4, rdy5;

	conv_t              conv_in;
	logic [VALUE_W-1:0] value_u;

	// serializer state
	logic                                 busy_q;
	logic                                 neg_pending_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits_q;
	logic [IDX_W-1:0]                     idx_q;

	logic out_fire;
	logic last_char;
	logic ser_free;
	logic load;

	// magnitude at 32 bits unsigned: the most negative value maps to 0x80000000
	assign value_u = $unsigned(value);
	always_comb begin
		conv_in.neg = value_u[VALUE_W-1];
		conv_in.bcd = '0;
		conv_in.bin = value_u[VALUE_W-1] ? (~value_u + 1'b1) : value_u;
	end

	// backpressure: a stage may take new data when empty or when it moves on
	assign last_char = !neg_pending_q && (idx_q == '0);
	assign out_fire  = char_valid && !char_stall;
	assign ser_free  = !busy_q || (out_fire && last_char);
	assign load      = vld_s5 && ser_free;

	assign rdy5 = !vld_s5 || ser_free;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign value_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= value_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (load) begin
				busy_q <= 1'b1;
			end else if (out_fire && last_char) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: no reset needed
	always_ff @(posedge clk) begin
		if (rdy1) data_s1 <= conv_in;
		if (rdy2) data_s2 <= dabble_steps(data_s1);
		if (rdy3) data_s3 <= dabble_steps(data_s2);
		if (rdy4) data_s4 <= dabble_steps(data_s3);
		if (rdy5) data_s5 <= dabble_steps(data_s4);

		if (load) begin
			neg_pending_q <= data_s5.neg;
			digits_q      <= data_s5.bcd;
			idx_q         <= top_digit(data_s5.bcd);
		end else if (out_fire) begin
			if (neg_pending_q) begin
				neg_pending_q <= 1'b0;
			end else if (idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	assign char_valid = busy_q;
	assign char_code  = neg_pending_q ? CH_MINUS : (CH_ZERO + {4'b0000, digits_q[idx_q]});
	assign last       = last_char;

endmodule

@@ rtl/core/sitda_chk.sv @@
module sitda_chk
	import sitda_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic signed [VALUE_W-1:0] value,
	input logic                      value_valid,
	input logic                      value_stall,
	input logic [7:0]                char_code,
	input logic                      last,
	input logic                      char_valid,
	input logic                      char_stall
);

	logic out_fire;
	assign out_fire = char_valid && !char_stall;

	// a stalled input item stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && value_stall |=> value_valid && $stable(value))
		else $error("stalled input item changed");

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_code) && $stable(last))
		else $error("stalled character changed");

	// only '-' or a decimal digit is ever shown
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (char_code == CH_MINUS) ||
			(char_code >= CH_ZERO && char_code <= CH_ZERO + 8'd9))
		else $error("character outside sign and digits");

	// a sign never ends a number
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_code == CH_MINUS |-> !last)
		else $error("sign marked last");

	// right after a sign comes a nonzero digit, with no gap
	a_after_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && char_code == CH_MINUS |=>
			char_valid && char_code != CH_MINUS && char_code != CH_ZERO)
		else $error("bad character after sign");

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_sitda_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.value       (value),
	.value_valid (value_valid),
	.value_stall (value_stall),
	.char_code   (char_code),
	.last        (last),
	.char_valid  (char_valid),
	.char_stall  (char_stall)
);
